// ===== design/rsrt_pkg.sv =====
// Shared widths and operation codes for the request skip remainder table.
package rsrt_pkg;

  // Payload widths.
  localparam int CLIENT_W = 16;
  localparam int LEN_W    = 48;

  // Operation codes carried on the opcode field.
  localparam logic OP_CHECK     = 1'b0;
  localparam logic OP_TERMINATE = 1'b1;

endpackage

// ===== design/request_skip_remainder_table.sv =====
// Ring table of client ids and discard remainders with a sequenced scan and shared subtractor.
// Sequence: a terminate transaction goes from acceptance straight to the subtract step; a check
// transaction first scans the slots in order until a matching slot or the last slot, then subtracts.
// Throughput: one transaction at a time; no new item is taken until the current one has passed
// its result to the output register. The slot scan issues one table read per cycle, one pipelined compare.
// Reset: synchronous, active low; the slot valid flags clear at once, so the table reads as
// empty and the ring pointer returns to slot 0 without a clearing pass.
module request_skip_remainder_table #(
  parameter int ENTRIES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [rsrt_pkg::CLIENT_W-1:0]  in_client_id,
  input  logic [rsrt_pkg::LEN_W-1:0]     in_packet_len,
  input  logic [rsrt_pkg::LEN_W-1:0]     in_frame_len,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ignore,
  output logic [rsrt_pkg::LEN_W-1:0]     out_remaining
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUB
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          op_r, op_nxt;
  logic [rsrt_pkg::CLIENT_W-1:0] cid_r, cid_nxt;
  logic [rsrt_pkg::LEN_W-1:0]    plen_r, plen_nxt;
  logic [rsrt_pkg::LEN_W-1:0]    opa_r, opa_nxt;
  logic                          hit_r, hit_nxt;
  logic [IW-1:0]                 hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]                 scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]                 eval_idx_r, eval_idx_nxt;
  logic                          data_ok_r, data_ok_nxt;
  logic [IW-1:0]                 wp_r, wp_nxt;
  logic [ENTRIES-1:0]            valid_r, valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ignore_r, out_ignore_nxt;
  logic [rsrt_pkg::LEN_W-1:0]    out_remaining_r, out_remaining_nxt;

  // Table storage and its registered read port.
  logic [rsrt_pkg::CLIENT_W-1:0] mem_client [ENTRIES];
  logic [rsrt_pkg::LEN_W-1:0]    mem_rem [ENTRIES];
  logic [rsrt_pkg::CLIENT_W-1:0] rd_client_r;
  logic [rsrt_pkg::LEN_W-1:0]    rd_rem_r;
  logic                          rd_valid_r;

  logic                          wr_en;
  logic [IW-1:0]                 wr_idx;

  // Shared subtractor and its derived results.
  logic [rsrt_pkg::LEN_W:0]      diff;
  logic                          borrow;
  logic                          term_ok;
  logic [rsrt_pkg::LEN_W-1:0]    sub_rem;
  logic                          slot_hit;
  logic                          out_free;
  logic                          in_accept;

  assign diff     = {1'b0, opa_r} - {1'b0, plen_r};
  assign borrow   = diff[rsrt_pkg::LEN_W];
  assign sub_rem  = borrow ? '0 : diff[rsrt_pkg::LEN_W-1:0];
  assign term_ok  = !borrow && (diff[rsrt_pkg::LEN_W-1:0] != '0);

  // A slot matches when it holds data, the client agrees and bytes are still owed.
  assign slot_hit = rd_valid_r && (rd_client_r == cid_r) && (rd_rem_r != '0);

  // The output register can take a new result this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && (state_r == ST_IDLE);

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_ignore    = out_ignore_r;
  assign out_remaining = out_remaining_r;

  // The table is written at most once per item, at the end of the subtract step.
  assign wr_en  = (state_r == ST_SUB) && out_free &&
                  (((op_r == rsrt_pkg::OP_CHECK) && hit_r) ||
                   ((op_r == rsrt_pkg::OP_TERMINATE) && term_ok));
  assign wr_idx = (op_r == rsrt_pkg::OP_TERMINATE) ? wp_r : hit_idx_r;

  // Table memory: one write port, one registered read port at the scan index.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_client[wr_idx] <= cid_r;
      mem_rem[wr_idx]    <= sub_rem;
    end
    rd_client_r <= mem_client[scan_idx_r];
    rd_rem_r    <= mem_rem[scan_idx_r];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    cid_nxt           = cid_r;
    plen_nxt          = plen_r;
    opa_nxt           = opa_r;
    hit_nxt           = hit_r;
    hit_idx_nxt       = hit_idx_r;
    scan_idx_nxt      = scan_idx_r;
    eval_idx_nxt      = eval_idx_r;
    data_ok_nxt       = data_ok_r;
    wp_nxt            = wp_r;
    valid_nxt         = valid_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_ignore_nxt    = out_ignore_r;
    out_remaining_nxt = out_remaining_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          op_nxt       = in_opcode;
          cid_nxt      = in_client_id;
          plen_nxt     = in_packet_len;
          opa_nxt      = in_frame_len;
          hit_nxt      = 1'b0;
          scan_idx_nxt = '0;
          data_ok_nxt  = 1'b0;
          state_nxt    = (in_opcode == rsrt_pkg::OP_TERMINATE) ? ST_SUB : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous slot is compared.
        data_ok_nxt  = 1'b1;
        eval_idx_nxt = scan_idx_r;
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (data_ok_r) begin
          if (slot_hit) begin
            opa_nxt     = rd_rem_r;
            hit_nxt     = 1'b1;
            hit_idx_nxt = eval_idx_r;
            state_nxt   = ST_SUB;
          end else if (eval_idx_r == LAST_IDX) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_SUB;
          end
        end
      end

      ST_SUB: begin
        // Finish the item once the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (op_r == rsrt_pkg::OP_CHECK) begin
            out_ignore_nxt    = hit_r;
            out_remaining_nxt = hit_r ? sub_rem : '0;
          end else begin
            out_ignore_nxt    = 1'b0;
            out_remaining_nxt = term_ok ? sub_rem : '0;
            if (term_ok) begin
              valid_nxt[wp_r] = 1'b1;
              wp_nxt          = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_r       <= 1'b0;
      scan_idx_r  <= '0;
      eval_idx_r  <= '0;
      data_ok_r   <= 1'b0;
      wp_r        <= '0;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      scan_idx_r  <= scan_idx_nxt;
      eval_idx_r  <= eval_idx_nxt;
      data_ok_r   <= data_ok_nxt;
      wp_r        <= wp_nxt;
      valid_r     <= valid_nxt;
      rd_valid_r  <= valid_r[scan_idx_r];
      out_valid_r <= out_valid_nxt;
    end
    op_r            <= op_nxt;
    cid_r           <= cid_nxt;
    plen_r          <= plen_nxt;
    opa_r           <= opa_nxt;
    hit_idx_r       <= hit_idx_nxt;
    out_ignore_r    <= out_ignore_nxt;
    out_remaining_r <= out_remaining_nxt;
  end

endmodule

// ===== design/rsrt_checker.sv =====
// Port-level checker for the request skip remainder table and its bind statement.
module rsrt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ignore,
  input logic [rsrt_pkg::LEN_W-1:0]    out_remaining
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ignore) && $stable(out_remaining))
    else $error("stalled result changed");

  // An accepted transaction keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a transaction");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

endmodule

bind request_skip_remainder_table rsrt_checker u_rsrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ignore    (out_ignore),
  .out_remaining (out_remaining)
);

// ===== bench/tb_request_skip_remainder_table.sv =====
// Testbench for the request skip remainder table: directed and random traffic against a predictor.
module tb_request_skip_remainder_table;

  localparam int ENTRIES     = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [rsrt_pkg::LEN_W-1:0] LEN_MAX = '1;

  typedef logic [rsrt_pkg::CLIENT_W-1:0] client_t;
  typedef logic [rsrt_pkg::LEN_W-1:0]    len_t;

  typedef struct packed {
    logic                       ignored;
    logic [rsrt_pkg::LEN_W-1:0] remaining;
  } verdict_t;

  // Predicts the skip table's answers and checks results in order.
  class skip_table_scoreboard;
    bit [rsrt_pkg::CLIENT_W-1:0] slot_client[ENTRIES];
    bit [rsrt_pkg::LEN_W-1:0]    slot_remaining[ENTRIES];
    int                          next_slot;
    int                          errors;
    verdict_t                    verdicts[$];

    // Updates the table copy for one accepted transaction and queues its answer.
    function void note_request(logic op, logic [rsrt_pkg::CLIENT_W-1:0] cid,
                               logic [rsrt_pkg::LEN_W-1:0] plen,
                               logic [rsrt_pkg::LEN_W-1:0] flen);
      verdict_t v;
      bit       found;
      v = '0;
      found = 0;
      if (op == rsrt_pkg::OP_CHECK) begin
        // The first slot of this client with bytes left takes the decrement.
        for (int k = 0; k < ENTRIES; k++) begin
          if (!found && slot_client[k] == cid && slot_remaining[k] != 0) begin
            found = 1;
            slot_remaining[k] = (slot_remaining[k] > plen) ? slot_remaining[k] - plen : '0;
            v.ignored = 1'b1;
            v.remaining = slot_remaining[k];
          end
        end
      end else if (flen > plen) begin
        slot_client[next_slot] = cid;
        slot_remaining[next_slot] = flen - plen;
        next_slot = (next_slot + 1) % ENTRIES;
        v.remaining = flen - plen;
      end
      verdicts.push_back(v);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(logic ignored, logic [rsrt_pkg::LEN_W-1:0] remaining);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, actual ignore %0d remaining %0d",
                 $time, ignored, remaining);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (ignored !== v.ignored) begin
        $display("%0t: ignore mismatch: expected %0d, actual %0d", $time, v.ignored, ignored);
        errors++;
      end
      if (remaining !== v.remaining) begin
        $display("%0t: remaining mismatch: expected %0d, actual %0d",
                 $time, v.remaining, remaining);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_opcode;
  logic [rsrt_pkg::CLIENT_W-1:0] in_client_id;
  logic [rsrt_pkg::LEN_W-1:0]    in_packet_len;
  logic [rsrt_pkg::LEN_W-1:0]    in_frame_len;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_ignore;
  logic [rsrt_pkg::LEN_W-1:0]    out_remaining;

  skip_table_scoreboard          sb;
  int                            tx_idle_pct;
  int                            rx_idle_pct;
  bit                            hold_rx;
  int                            quiet_cycles;
  logic [rsrt_pkg::CLIENT_W-1:0] client_pool[4];

  request_skip_remainder_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_client_id (in_client_id),
    .in_packet_len(in_packet_len),
    .in_frame_len (in_frame_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ignore   (out_ignore),
    .out_remaining(out_remaining)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side stalls at random, or for a whole stretch while hold_rx is set.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_rx || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Record accepted transactions on both channels and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_ignore, out_remaining);
      if (in_valid && !in_stall)
        sb.note_request(in_opcode, in_client_id, in_packet_len, in_frame_len);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic logic [rsrt_pkg::LEN_W-1:0] rand48();
    return len_t'({$urandom, $urandom});
  endfunction

  // Mostly short lengths so remainders last several packets, with some full-range values.
  function automatic logic [rsrt_pkg::LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return LEN_MAX;
      2, 3:    return rand48();
      default: return len_t'($urandom_range(3000, 1));
    endcase
  endfunction

  function automatic logic [rsrt_pkg::CLIENT_W-1:0] pick_client();
    if ($urandom_range(9) == 0) return client_t'($urandom);
    return client_pool[$urandom_range(3)];
  endfunction

  // Offers one transaction, starting and ending at a falling edge.
  task automatic send_item(logic op, logic [rsrt_pkg::CLIENT_W-1:0] cid,
                           logic [rsrt_pkg::LEN_W-1:0] plen,
                           logic [rsrt_pkg::LEN_W-1:0] flen);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_client_id  <= cid;
    in_packet_len <= plen;
    in_frame_len  <= flen;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Random traffic: terminates open skip windows, checks eat into them.
  task automatic run_traffic(int count);
    logic [rsrt_pkg::LEN_W-1:0] plen;
    logic [rsrt_pkg::LEN_W-1:0] flen;
    for (int n = 0; n < count; n++) begin
      plen = pick_len();
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(9))
          0:       flen = plen;
          1:       flen = rand48();
          default: flen = plen + len_t'($urandom_range(20000, 1));
        endcase
        send_item(rsrt_pkg::OP_TERMINATE, pick_client(), plen, flen);
      end else begin
        send_item(rsrt_pkg::OP_CHECK, pick_client(), plen, rand48());
      end
    end
  endtask

  task automatic hold_receiver(int cycles);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rx = 1'b0;
  endtask

  // Main sequence.
  initial begin
    sb = new;
    hold_rx = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 48;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = rsrt_pkg::OP_CHECK;
    in_client_id = '0;
    in_packet_len = '0;
    in_frame_len = '0;
    foreach (client_pool[i]) client_pool[i] = client_t'($urandom);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: client zero matches every slot, but zero remainders are skipped.
    send_item(rsrt_pkg::OP_CHECK, 16'h0000, '0, '0);
    send_item(rsrt_pkg::OP_TERMINATE, 16'h1234, 48'd100, 48'd1000);
    // Packet not shorter than the frame stores nothing.
    send_item(rsrt_pkg::OP_TERMINATE, 16'h1234, 48'd500, 48'd500);
    send_item(rsrt_pkg::OP_TERMINATE, 16'h1234, LEN_MAX, '0);
    send_item(rsrt_pkg::OP_CHECK, 16'h1234, '0, LEN_MAX);
    send_item(rsrt_pkg::OP_CHECK, 16'h1234, 48'd300, '0);
    // Decrement past zero saturates and still reports ignore.
    send_item(rsrt_pkg::OP_CHECK, 16'h1234, 48'd1000, '0);
    send_item(rsrt_pkg::OP_CHECK, 16'h1234, 48'd1, '0);
    send_item(rsrt_pkg::OP_TERMINATE, 16'hFFFF, '0, LEN_MAX);
    send_item(rsrt_pkg::OP_CHECK, 16'hFFFF, LEN_MAX, LEN_MAX);
    send_item(rsrt_pkg::OP_TERMINATE, 16'h0000, '0, 48'd1);
    send_item(rsrt_pkg::OP_CHECK, 16'h0000, LEN_MAX, '0);
    // Wrap the ring so the oldest slot is overwritten.
    for (int i = 0; i < 9; i++)
      send_item(rsrt_pkg::OP_TERMINATE, client_t'(16'h0100 + i), 48'd0, 48'd1000 * (i + 1));
    send_item(rsrt_pkg::OP_CHECK, 16'h0100, 48'd10, '0);
    // The same client in two slots: the lower index wins.
    send_item(rsrt_pkg::OP_TERMINATE, 16'h0102, '0, 48'd77);
    send_item(rsrt_pkg::OP_CHECK, 16'h0102, 48'd7, '0);
    send_item(rsrt_pkg::OP_CHECK, 16'h0108, 48'd8, '0);

    // Phase one, with a long receiver hold-off so the block backs up its input.
    run_traffic(200);
    fork
      hold_receiver(80);
      run_traffic(20);
    join
    drain();
    run_traffic(220);
    drain();

    // Phase two: the idle rates swap.
    tx_idle_pct = 48;
    rx_idle_pct = 31;
    run_traffic(430);
    drain();

    // Phase three: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(410);
    drain();

    repeat (ENTRIES + 6) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rsrt_pkg.sv
design/request_skip_remainder_table.sv
design/rsrt_checker.sv
bench/tb_request_skip_remainder_table.sv
